// ----- hdl/sm3_hash_engine_macros.svh -----
// ----------------------------------------------------------------------------
// SM3 hash engine assertion macros
// Shorthand for the concurrent checks of the hash engine.
// ----------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_MACROS_SVH
`define SM3_HASH_ENGINE_MACROS_SVH

// check in the same cycle
`define SM3_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check in the following cycle
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// SM3 package
// Types, constants and round helper functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [7:0]       byte_type;
   typedef logic [0:7][31:0] cv_type;

   typedef enum logic {
      CMD_ABSORB = 1'b0,
      CMD_FINISH = 1'b1
   } cmd_type;

   localparam word_type T_LOW    = 32'h79CC4519;
   localparam word_type T_HIGH   = 32'h7A879D8A;
   localparam byte_type PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS   = 6'd56;
   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD = 3'd7;

   localparam cv_type IV = {
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   function automatic word_type rol32(input word_type x, input logic [4:0] r);
      logic [63:0] d;
      d = {x, x} << r;
      return d[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
   endfunction

   function automatic word_type t_rot(input logic [5:0] j);
      return rol32((j[5:4] == 2'b00) ? T_LOW : T_HIGH, j[4:0]);
   endfunction

endpackage

// ----- hdl/sm3_req_if.sv -----
// ----------------------------------------------------------------------------
// SM3 request channel
// Valid/ready channel carrying one command and one message byte.
// ----------------------------------------------------------------------------
interface sm3_req_if;
   import sm3_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  command;
   byte_type data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);

endinterface

// ----- hdl/sm3_rsp_if.sv -----
// ----------------------------------------------------------------------------
// SM3 response channel
// Valid/ready channel carrying one digest word with its position.
// ----------------------------------------------------------------------------
interface sm3_rsp_if;
   import sm3_pkg::*;

   logic       valid;
   logic       ready;
   word_type   digest_word;
   logic [2:0] word_index;
   logic       last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);

endinterface

// ----- hdl/sm3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streaming SM3 hash with one shared round unit under a small sequencer.
//
// req_chan takes one item per transfer: command CMD_ABSORB adds data_byte
// to the message, CMD_FINISH pads the message and starts the digest.
// rsp_chan returns the digest as eight 32-bit words, word_index 0 first,
// last_word set on word 7.
// An absorbed byte enters the block window; the byte that completes a 64-byte
// block starts the rounds of the shared round unit. A finish pads one byte per
// cycle through the same byte path, pausing for the rounds of each block it
// completes (one or two blocks), then presents
// the eight words, one per cycle while rsp_chan.ready is high.
// While the round unit runs, no new byte is taken.
// req_chan.ready is high only while the engine waits for an item.
// A stalled receiver holds the current digest word; nothing is lost.
// After word 7 transfers, the chaining value returns to the initial
// value and a new message may start. Synchronous reset does the same.
// ----------------------------------------------------------------------------
`include "sm3_hash_engine_macros.svh"

module sm3_hash_engine (
   input logic clock,
   input logic reset,
   sm3_req_if.sink   req_chan,
   sm3_rsp_if.source rsp_chan
);
   import sm3_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ROUND = 4'b0010,
      S_PAD   = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  bitcnt_ff, bitcnt_in;
   logic [511:0] win_ff, win_in;
   cv_type       v_ff, v_in;
   cv_type       cv_ff, cv_in;
   logic [5:0]   round_ff, round_in;
   logic         fin_ff, fin_in;
   logic         mark_ff, mark_in;
   logic         len_ff, len_in;
   logic [2:0]   oidx_ff, oidx_in;

   logic         req_xfer, rsp_xfer;
   logic         push_en;
   byte_type     push_byte;
   logic [63:0]  len_shift;
   logic         use_len;

   word_type w0, w3, w4, w7, w10, w13, nw;
   word_type a12, ss1, ss2, fv, gv, tt1, tt2;
   cv_type   vnext;

   assign req_xfer = req_chan.valid & req_chan.ready;
   assign rsp_xfer = rsp_chan.valid & rsp_chan.ready;

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = (state_ff == S_OUT);
   assign rsp_chan.digest_word = cv_ff[oidx_ff];
   assign rsp_chan.word_index  = oidx_ff;
   assign rsp_chan.last_word   = (oidx_ff == LAST_WORD);

   assign len_shift = bitcnt_ff >> {~fill_ff[2:0], 3'b000};
   assign use_len   = len_ff | (fill_ff == LEN_POS);

   always_comb begin
      if (!mark_ff) begin
         push_byte = PAD_BYTE;
      end else if (use_len) begin
         push_byte = len_shift[7:0];
      end else begin
         push_byte = 8'h00;
      end
      if (state_ff == S_IDLE) begin
         push_byte = req_chan.data_byte;
      end
   end

   assign push_en = (req_xfer & (req_chan.command == CMD_ABSORB)) | (state_ff == S_PAD);

   assign w0  = win_ff[511:480];
   assign w3  = win_ff[415:384];
   assign w4  = win_ff[383:352];
   assign w7  = win_ff[287:256];
   assign w10 = win_ff[191:160];
   assign w13 = win_ff[95:64];
   assign nw  = perm1(w0 ^ w7 ^ rol32(w13, 5'd15)) ^ rol32(w3, 5'd7) ^ w10;

   always_comb begin
      a12 = rol32(v_ff[0], 5'd12);
      ss1 = rol32(a12 + v_ff[4] + t_rot(round_ff), 5'd7);
      ss2 = ss1 ^ a12;
      if (round_ff[5:4] == 2'b00) begin
         fv = v_ff[0] ^ v_ff[1] ^ v_ff[2];
         gv = v_ff[4] ^ v_ff[5] ^ v_ff[6];
      end else begin
         fv = (v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]);
         gv = (v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]);
      end
      tt1 = fv + v_ff[3] + ss2 + (w0 ^ w4);
      tt2 = gv + v_ff[7] + ss1 + w0;
      vnext = {tt1, v_ff[0], rol32(v_ff[1], 5'd9), v_ff[2],
               perm0(tt2), v_ff[4], rol32(v_ff[5], 5'd19), v_ff[6]};
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      bitcnt_in = bitcnt_ff;
      win_in    = win_ff;
      v_in      = v_ff;
      cv_in     = cv_ff;
      round_in  = round_ff;
      fin_in    = fin_ff;
      mark_in   = mark_ff;
      len_in    = len_ff;
      oidx_in   = oidx_ff;

      if (push_en) begin
         win_in  = {win_ff[503:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff == LAST_FILL) begin
            state_in = S_ROUND;
            round_in = 6'd0;
            v_in     = cv_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_chan.command == CMD_ABSORB) begin
                  bitcnt_in = bitcnt_ff + 64'd8;
               end else begin
                  fin_in   = 1'b1;
                  mark_in  = 1'b0;
                  len_in   = 1'b0;
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            mark_in = 1'b1;
            if (mark_ff && (fill_ff == LEN_POS)) begin
               len_in = 1'b1;
            end
         end
         S_ROUND: begin
            v_in     = vnext;
            win_in   = {win_ff[479:0], nw};
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               round_in = 6'd0;
               oidx_in  = 3'd0;
               for (int i = 0; i < 8; i++) begin
                  cv_in[i] = cv_ff[i] ^ vnext[i];
               end
               if (!fin_ff) begin
                  state_in = S_IDLE;
               end else if (len_ff) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_PAD;
               end
            end
         end
         S_OUT: begin
            if (rsp_xfer) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == LAST_WORD) begin
                  cv_in     = IV;
                  bitcnt_in = 64'd0;
                  fill_in   = 6'd0;
                  fin_in    = 1'b0;
                  mark_in   = 1'b0;
                  len_in    = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= 6'd0;
         bitcnt_ff <= 64'd0;
         cv_ff     <= IV;
         round_ff  <= 6'd0;
         fin_ff    <= 1'b0;
         mark_ff   <= 1'b0;
         len_ff    <= 1'b0;
         oidx_ff   <= 3'd0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bitcnt_ff <= bitcnt_in;
         cv_ff     <= cv_in;
         round_ff  <= round_in;
         fin_ff    <= fin_in;
         mark_ff   <= mark_in;
         len_ff    <= len_in;
         oidx_ff   <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      v_ff   <= v_in;
   end

   `SM3_ASSERT_SAME(a_out_block_empty, clock, reset, (state_ff == S_OUT), (fill_ff == 6'd0 && len_ff), "digest shown with partial block")
   `SM3_ASSERT_SAME(a_round_idle_zero, clock, reset, (round_ff != 6'd0), (state_ff == S_ROUND), "round counter moved outside rounds")
   `SM3_ASSERT_NEXT(a_digest_clears, clock, reset, (rsp_xfer && rsp_chan.last_word), (state_ff == S_IDLE && bitcnt_ff == 64'd0 && cv_ff == IV), "state not restored after digest")
   `SM3_ASSERT_NEXT(a_block_starts_rounds, clock, reset, (req_xfer && req_chan.command == CMD_ABSORB && fill_ff == LAST_FILL), (state_ff == S_ROUND && round_ff == 6'd0), "full block did not start compression")

endmodule

// ----- bench/sm3_hash_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams byte messages of boundary and random lengths through the engine,
// predicts each 256-bit digest with a local SM3 model and compares every
// digest word as it transfers, under phases of sender idling and receiver
// stalls, long receiver hold-offs and full drains between phases.
// ----------------------------------------------------------------------------
module sm3_hash_engine_tb;
   import sm3_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 28;
   localparam int MIN_FINISHES    = 9;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      word_type   word;
      logic [2:0] index;
      logic       last;
   } digest_entry_type;

   class sm3_digest_board;
      word_type         chain[8];
      byte_type         block[64];
      int unsigned      fill;
      logic [63:0]      bit_len;
      digest_entry_type words_due[$];
      int               mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = IV[i];
         fill    = 0;
         bit_len = '0;
      endfunction

      static function word_type rotl(word_type x, int unsigned r);
         r = r % 32;
         return (r == 0) ? x : ((x << r) | (x >> (32 - r)));
      endfunction

      static function word_type mix0(word_type x);
         return x ^ rotl(x, 9) ^ rotl(x, 17);
      endfunction

      static function word_type mix1(word_type x);
         return x ^ rotl(x, 15) ^ rotl(x, 23);
      endfunction

      function void compress();
         word_type w[68];
         word_type a, b, c, d, e, f, g, h;
         word_type ss1, ss2, tt1, tt2, ff, gg, tj;
         for (int i = 0; i < 16; i++)
            w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
         for (int i = 16; i < 68; i++)
            w[i] = mix1(w[i-16] ^ w[i-9] ^ rotl(w[i-3], 15)) ^ rotl(w[i-13], 7) ^ w[i-6];
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? T_LOW : T_HIGH;
            ss1 = rotl(rotl(a, 12) + e + rotl(tj, j), 7);
            ss2 = ss1 ^ rotl(a, 12);
            if (j < 16) begin
               ff = a ^ b ^ c;
               gg = e ^ f ^ g;
            end else begin
               ff = (a & b) | (a & c) | (b & c);
               gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rotl(b, 9); b = a; a = tt1;
            h = g; g = rotl(f, 19); f = e; e = mix0(tt2);
         end
         chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
         chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
      endfunction

      function void push(byte_type value);
         block[fill] = value;
         fill++;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      endfunction

      function void note_transfer(cmd_type cmd, byte_type value);
         logic [63:0]      len;
         digest_entry_type entry;
         if (cmd == CMD_ABSORB) begin
            bit_len += 64'd8;
            push(value);
         end else begin
            len = bit_len;
            push(PAD_BYTE);
            while (fill != LEN_POS) push(8'h00);
            for (int i = 0; i < 8; i++) push(len[63-8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
               entry.word  = chain[i];
               entry.index = 3'(i);
               entry.last  = (3'(i) == LAST_WORD);
               words_due.push_back(entry);
            end
            restart();
         end
      endfunction

      function void report(string what, digest_entry_type due, word_type word,
                           logic [2:0] index, logic last);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%t %s: expected %h/%0d/%b got %h/%0d/%b", $realtime, what,
                     due.word, due.index, due.last, word, index, last);
      endfunction

      function void check_word(word_type word, logic [2:0] index, logic last);
         digest_entry_type due;
         if (words_due.size() == 0) begin
            due = '{'0, '0, 1'b0};
            report("unexpected digest word", due, word, index, last);
            return;
         end
         due = words_due.pop_front();
         if (due.word !== word || due.index !== index || due.last !== last)
            report("digest word mismatch", due, word, index, last);
      endfunction
   endclass

   logic clock;
   logic reset;

   sm3_req_if req_chan ();
   sm3_rsp_if rsp_chan ();

   sm3_hash_engine u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sm3_digest_board board = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int finishes       = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= HOLD_OFF_CYCLES;
         hold_served    <= hold_served + 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_word(rsp_chan.digest_word, rsp_chan.word_index, rsp_chan.last_word);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_item(cmd_type cmd, byte_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.command   <= cmd;
      req_chan.data_byte <= value;
      do @(posedge clock); while (!req_chan.ready);
      board.note_transfer(cmd, value);
      if (cmd == CMD_FINISH) finishes++;
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++) send_item(CMD_ABSORB, byte_type'($urandom));
      send_item(CMD_FINISH, byte_type'($urandom));
   endtask

   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      while (board.words_due.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_length();
      int edges[8] = '{54, 55, 56, 57, 62, 63, 64, 65};
      int sel;
      sel = $urandom_range(19);
      if (sel < 9) return $urandom_range(8);
      if (sel < 16) return edges[$urandom_range(7)];
      if (sel < 19) return $urandom_range(70);
      return $urandom_range(121, 118);
   endfunction

   initial begin
      int phase_items;
      int len;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.command   <= CMD_ABSORB;
      req_chan.data_byte <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message, "abc", byte extremes, finish byte ignored
      send_item(CMD_FINISH, 8'h00);
      send_item(CMD_ABSORB, 8'h61);
      send_item(CMD_ABSORB, 8'h62);
      send_item(CMD_ABSORB, 8'h63);
      send_item(CMD_FINISH, 8'hFF);
      send_item(CMD_ABSORB, 8'h00);
      send_item(CMD_ABSORB, 8'hFF);
      send_item(CMD_FINISH, 8'h00);
      send_item(CMD_ABSORB, 8'h55);
      send_item(CMD_ABSORB, 8'hAA);
      send_item(CMD_FINISH, 8'hA5);
      pause_until_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         if (phase == 0 || phase == 3) hold_requests++;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS || (phase == 3 && finishes < MIN_FINISHES)) begin
            len = pick_length();
            send_message(len);
            phase_items += len + 1;
         end
         pause_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.words_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/sm3_pkg.sv
hdl/sm3_req_if.sv
hdl/sm3_rsp_if.sv
hdl/sm3_hash_engine.sv
bench/sm3_hash_engine_tb.sv
